// ===== rtl/lmdr_pkg.sv =====
// shared types, constants and glyph table of the led matrix delta refresh unit
`timescale 1ns / 1ps
package lmdr_pkg;

  // matrix geometry
  localparam int ROWS   = 7;
  localparam int COLS   = 7;
  localparam int GLYPH  = 7;
  localparam int DIGITS = 10;
  localparam int CELLS  = ROWS * COLS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int IDX_W  = $clog2(CELLS);

  // field widths
  localparam int COLOR_W   = 24;
  localparam int POS_W     = 3;
  localparam int DIGIT_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 64;
  localparam int OUT_W     = 32;

  // command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VACATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL   = 1'd1;

  typedef enum logic [1:0] {
    KIND_MOVE,
    KIND_FILL,
    KIND_DIGIT,
    KIND_NOP
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE_FROM,
    ST_MOVE_TO,
    ST_DRAW,
    ST_SCAN,
    ST_DRAIN
  } st_t;

  // one classified command waiting for the back end
  typedef struct packed {
    kind_t              kind;
    logic               from_ok;
    logic [IDX_W-1:0]   from_idx;
    logic               to_ok;
    logic [IDX_W-1:0]   to_idx;
    logic [COLOR_W-1:0] paint;
    logic [COLOR_W-1:0] back;
    logic [DIGIT_W-1:0] digit;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // digit glyphs, bit c of a row set means column c is foreground
  localparam logic [GLYPH-1:0] GLYPHS [DIGITS][GLYPH] = '{
    '{7'h1C, 7'h22, 7'h22, 7'h22, 7'h22, 7'h22, 7'h1C},
    '{7'h10, 7'h18, 7'h14, 7'h12, 7'h10, 7'h10, 7'h10},
    '{7'h1C, 7'h22, 7'h20, 7'h1C, 7'h02, 7'h02, 7'h04},
    '{7'h1C, 7'h22, 7'h20, 7'h1C, 7'h20, 7'h22, 7'h1C},
    '{7'h10, 7'h18, 7'h14, 7'h3E, 7'h10, 7'h10, 7'h10},
    '{7'h3E, 7'h02, 7'h02, 7'h1E, 7'h20, 7'h20, 7'h1E},
    '{7'h1C, 7'h22, 7'h02, 7'h1E, 7'h22, 7'h22, 7'h1C},
    '{7'h3E, 7'h20, 7'h20, 7'h38, 7'h20, 7'h20, 7'h20},
    '{7'h1C, 7'h22, 7'h22, 7'h1C, 7'h22, 7'h22, 7'h1C},
    '{7'h1C, 7'h22, 7'h22, 7'h3C, 7'h20, 7'h22, 7'h1C}
  };

  function automatic logic [GLYPH-1:0] glyph_row(input logic [DIGIT_W-1:0] d,
                                                 input logic [ROW_W-1:0] r);
    logic [GLYPH-1:0] bits;
    bits = '0;
    if ((int'(d) < DIGITS) && (int'(r) < GLYPH)) begin
      bits = GLYPHS[d][r];
    end
    return bits;
  endfunction

endpackage

// ===== rtl/lmdr_front.sv =====
// input side: unpacks beats, drops no-op commands, resolves cell indexes
`timescale 1ns / 1ps
module lmdr_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // from_row, from_col, to_row, to_col, paint_color, back_color, digit
  input  logic [lmdr_pkg::IN_W-1:0]    s_tdata,
  // kind
  input  logic [1:0]                   s_tuser,
  input  lmdr_pkg::q_stat_t            q_stat,
  output logic                         push,
  output lmdr_pkg::cmd_t               push_cmd
);

  logic [lmdr_pkg::POS_W-1:0]   from_row;
  logic [lmdr_pkg::POS_W-1:0]   from_col;
  logic [lmdr_pkg::POS_W-1:0]   to_row;
  logic [lmdr_pkg::POS_W-1:0]   to_col;
  logic [lmdr_pkg::DIGIT_W-1:0] digit;
  lmdr_pkg::kind_t              kind;
  logic                         drop;

  // field unpacking
  assign from_row = s_tdata[2:0];
  assign from_col = s_tdata[5:3];
  assign to_row   = s_tdata[8:6];
  assign to_col   = s_tdata[11:9];
  assign digit    = s_tdata[63:60];
  assign kind     = lmdr_pkg::kind_t'(s_tuser);

  // classify: unknown kind or digit above nine does nothing
  always_comb begin
    case (kind)
      lmdr_pkg::KIND_MOVE:  drop = 1'b0;
      lmdr_pkg::KIND_FILL:  drop = 1'b0;
      lmdr_pkg::KIND_DIGIT: drop = !(int'(digit) < lmdr_pkg::DIGITS);
      default:              drop = 1'b1;
    endcase
  end

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready && !drop;

  // command build, out-of-range cells flagged
  always_comb begin
    push_cmd.kind     = kind;
    push_cmd.from_ok  = (int'(from_row) < lmdr_pkg::ROWS) && (int'(from_col) < lmdr_pkg::COLS);
    push_cmd.from_idx = lmdr_pkg::IDX_W'(int'(from_row) * lmdr_pkg::COLS + int'(from_col));
    push_cmd.to_ok    = (int'(to_row) < lmdr_pkg::ROWS) && (int'(to_col) < lmdr_pkg::COLS);
    push_cmd.to_idx   = lmdr_pkg::IDX_W'(int'(to_row) * lmdr_pkg::COLS + int'(to_col));
    push_cmd.paint    = s_tdata[35:12];
    push_cmd.back     = s_tdata[59:36];
    push_cmd.digit    = digit;
  end

endmodule

// ===== rtl/lmdr_cmd_fifo.sv =====
// short command queue between the front and back ends
`timescale 1ns / 1ps
module lmdr_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lmdr_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output lmdr_pkg::cmd_t    pop_cmd,
  output lmdr_pkg::q_stat_t q_stat
);

  lmdr_pkg::cmd_t              q [lmdr_pkg::QDEPTH];
  logic [lmdr_pkg::QPTR_W-1:0] wr_ptr;
  logic [lmdr_pkg::QPTR_W-1:0] rd_ptr;
  logic [lmdr_pkg::QPTR_W:0]   count;

  assign q_stat.full  = (count == (lmdr_pkg::QPTR_W + 1)'(lmdr_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_cmd      = q[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lmdr_pkg::QPTR_W'(lmdr_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lmdr_pkg::QPTR_W'(lmdr_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lmdr_back.sv =====
// execution side: frame memories, draw and refresh sequencer, output register
`timescale 1ns / 1ps
module lmdr_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lmdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmdr_pkg::COLOR_W-1:0]      cfg_data,
  input  lmdr_pkg::q_stat_t                 q_stat,
  input  lmdr_pkg::cmd_t                    pop_cmd,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // led_row, led_col, led_red, led_green, led_blue, two zero bits
  output logic [lmdr_pkg::OUT_W-1:0]        m_tdata,
  output logic                              m_tlast
);

  localparam int ROW_W   = lmdr_pkg::ROW_W;
  localparam int COL_W   = lmdr_pkg::COL_W;
  localparam int IDX_W   = lmdr_pkg::IDX_W;
  localparam int COLOR_W = lmdr_pkg::COLOR_W;

  lmdr_pkg::st_t        state;
  lmdr_pkg::st_t        state_next;
  lmdr_pkg::cmd_t       cmd;
  logic [COLOR_W-1:0]   vacate_color;
  logic [COLOR_W-1:0]   fill_color;
  logic                 shown_valid;

  // frame memories
  logic [COLOR_W-1:0]   tgt_mem [lmdr_pkg::CELLS];
  logic [COLOR_W-1:0]   shd_mem [lmdr_pkg::CELLS];
  logic [lmdr_pkg::CELLS-1:0] tgt_vld;
  logic                 tgt_we;
  logic [IDX_W-1:0]     tgt_waddr;
  logic [COLOR_W-1:0]   tgt_wdata;

  // cell walk
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     draw_idx;
  logic [lmdr_pkg::GLYPH-1:0] glyph_bits;
  logic                 scan_end;
  logic                 draw_end;
  logic                 step;
  logic                 col_wrap;

  // compare stage
  logic                 s1_valid;
  logic [ROW_W-1:0]     s1_row;
  logic [COL_W-1:0]     s1_col;
  logic [IDX_W-1:0]     s1_idx;
  logic [COLOR_W-1:0]   s1_val;
  logic [COLOR_W-1:0]   shd_rd;
  logic                 s1_diff;
  logic                 s1_done;
  logic                 issue;
  logic                 fill_mode;

  // held write, so the final one of a refresh can be marked
  logic                 pend_valid;
  logic [ROW_W-1:0]     pend_row;
  logic [COL_W-1:0]     pend_col;
  logic [COLOR_W-1:0]   pend_val;
  logic                 out_free;
  logic                 pend_free;
  logic                 flush;
  logic                 out_load;

  // output register
  logic                 out_valid;
  logic [lmdr_pkg::POS_W-1:0] out_row;
  logic [lmdr_pkg::POS_W-1:0] out_col;
  logic [COLOR_W-1:0]   out_val;
  logic                 out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vacate_color <= '0;
      fill_color   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmdr_pkg::CFG_VACATE: vacate_color <= cfg_data;
        lmdr_pkg::CFG_FILL:   fill_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fill_mode  = (cmd.kind == lmdr_pkg::KIND_FILL);
  assign out_free   = !out_valid || m_tready;
  assign pend_free  = !pend_valid || out_free;
  assign s1_diff    = !shown_valid || (shd_rd != s1_val);
  assign s1_done    = s1_valid && (!s1_diff || pend_free);
  assign issue      = (state == lmdr_pkg::ST_SCAN) && (!s1_valid || s1_done);
  assign flush      = (state == lmdr_pkg::ST_DRAIN) && !s1_valid && (!pend_valid || out_free);
  assign out_load   = (s1_done && s1_diff && pend_valid) || (flush && pend_valid);
  assign scan_end   = (row == ROW_W'(lmdr_pkg::ROWS - 1)) && (col == COL_W'(lmdr_pkg::COLS - 1));
  assign draw_end   = (row == ROW_W'(lmdr_pkg::GLYPH - 1)) && (col == COL_W'(lmdr_pkg::GLYPH - 1));
  assign draw_idx   = IDX_W'(int'(row) * lmdr_pkg::COLS + int'(col));
  assign glyph_bits = lmdr_pkg::glyph_row(cmd.digit, row);
  assign step       = issue || (state == lmdr_pkg::ST_DRAW);
  assign col_wrap   = (state == lmdr_pkg::ST_DRAW) ?
                      (col == COL_W'(lmdr_pkg::GLYPH - 1)) :
                      (col == COL_W'(lmdr_pkg::COLS - 1));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmdr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, queue pop and target write port
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    tgt_we     = 1'b0;
    tgt_waddr  = idx;
    tgt_wdata  = fill_color;
    case (state)
      lmdr_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (pop_cmd.kind)
            lmdr_pkg::KIND_MOVE:  state_next = lmdr_pkg::ST_MOVE_FROM;
            lmdr_pkg::KIND_FILL:  state_next = lmdr_pkg::ST_SCAN;
            lmdr_pkg::KIND_DIGIT: state_next = lmdr_pkg::ST_DRAW;
            default:              state_next = lmdr_pkg::ST_IDLE;
          endcase
        end
      end
      lmdr_pkg::ST_MOVE_FROM: begin
        tgt_we     = cmd.from_ok;
        tgt_waddr  = cmd.from_idx;
        tgt_wdata  = vacate_color;
        state_next = lmdr_pkg::ST_MOVE_TO;
      end
      lmdr_pkg::ST_MOVE_TO: begin
        tgt_we     = cmd.to_ok;
        tgt_waddr  = cmd.to_idx;
        tgt_wdata  = cmd.paint;
        state_next = lmdr_pkg::ST_SCAN;
      end
      lmdr_pkg::ST_DRAW: begin
        tgt_we    = 1'b1;
        tgt_waddr = draw_idx;
        tgt_wdata = glyph_bits[col] ? cmd.paint : cmd.back;
        if (draw_end) begin
          state_next = lmdr_pkg::ST_IDLE;
        end
      end
      lmdr_pkg::ST_SCAN: begin
        tgt_we = issue && fill_mode;
        if (issue && scan_end) begin
          state_next = lmdr_pkg::ST_DRAIN;
        end
      end
      lmdr_pkg::ST_DRAIN: begin
        if (flush) begin
          state_next = lmdr_pkg::ST_IDLE;
        end
      end
      default: state_next = lmdr_pkg::ST_IDLE;
    endcase
  end

  // command latch and cell walk counters
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_cmd;
    end
    if (rst || pop) begin
      row <= '0;
      col <= '0;
      idx <= '0;
    end else if (step) begin
      idx <= idx + 1'b1;
      if (col_wrap) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // target frame: storage, written-entry bits, registered scan read
  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata;
    end
    if (issue) begin
      s1_val <= fill_mode ? fill_color : (tgt_vld[idx] ? tgt_mem[idx] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_vld <= '0;
    end else if (tgt_we) begin
      tgt_vld[tgt_waddr] <= 1'b1;
    end
  end

  // shadow frame: read on issue, written when a changed cell moves to the held write
  always_ff @(posedge clk) begin
    if (s1_done && s1_diff) begin
      shd_mem[s1_idx] <= s1_val;
    end
    if (issue) begin
      shd_rd <= shd_mem[idx];
    end
  end

  // compare stage position
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_row <= row;
      s1_col <= col;
      s1_idx <= idx;
    end
  end

  // control of compare stage, held write, output beat and shadow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      shown_valid <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done && s1_diff) begin
        pend_valid <= 1'b1;
      end else if (flush) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (flush) begin
        shown_valid <= 1'b1;
      end
    end
  end

  // held write and output payload
  always_ff @(posedge clk) begin
    if (s1_done && s1_diff) begin
      pend_row <= s1_row;
      pend_col <= s1_col;
      pend_val <= s1_val;
    end
    if (out_load) begin
      out_row  <= lmdr_pkg::POS_W'(int'(pend_row) + 1);
      out_col  <= lmdr_pkg::POS_W'(int'(pend_col) + 1);
      out_val  <= pend_val;
      out_last <= flush;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_val[7:0], out_val[15:8], out_val[23:16], out_col, out_row};

endmodule

// ===== rtl/led_matrix_delta_refresh_unit.sv =====
// top level of the led matrix delta refresh unit
`timescale 1ns / 1ps
// Keeps a 7x7 RGB target frame and a shadow of what the LEDs show, and
// streams out one LED write for each cell that changed.
// Slave channel: one beat per command; kind on s_tuser (move, fill, digit).
// Move and fill end in a refresh; digit only draws into the target frame.
// Master channel: one beat per LED write, m_tlast on the final write of a
// refresh; a refresh with no changed cell gives no beats.
// Config port: cfg_we with cfg_index 0 = vacate colour, 1 = fill colour.
// Timing: a command queue of two entries sits between the input side and
// the sequencer. The sequencer walks the 49 cells one per cycle unless the
// output stalls, limited by the single read port of each frame memory; a
// move writes its two cells before its scan. Command kind 3 and digits
// above nine are dropped at the input. An LED write is held until the next
// changed cell is found or the scan ends, so the final one can be marked:
// with the queue empty, m_tvalid rises once a second changed cell is found
// or the scan ends, later when changes are sparse.
// When the receiver stalls, the output register and one held write fill
// and the cell walk pauses; the queue keeps taking commands until full.
// Reset clears the target frame to black (zero), both colour registers and
// the shadow, so the first refresh writes every LED. No clearing pass.
module led_matrix_delta_refresh_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // from_row, from_col, to_row, to_col, paint_color, back_color, digit
  input  logic [lmdr_pkg::IN_W-1:0]      s_tdata,
  // kind
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // led_row, led_col, led_red, led_green, led_blue, two zero bits
  output logic [lmdr_pkg::OUT_W-1:0]     m_tdata,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [lmdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmdr_pkg::COLOR_W-1:0]   cfg_data
);

  lmdr_pkg::q_stat_t q_stat;
  lmdr_pkg::cmd_t    push_cmd;
  lmdr_pkg::cmd_t    pop_cmd;
  logic              push;
  logic              pop;

  // input side
  lmdr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue
  lmdr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  // sequencer and frames
  lmdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== rtl/lmdr_checker.sv =====
// port checks of the led matrix delta refresh unit and their binding
`timescale 1ns / 1ps
module lmdr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [lmdr_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);

  // a stalled beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled LED write changed");

  // positions are 1-based, never zero
  a_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd0) && (m_tdata[5:3] != 3'd0))
    else $error("LED position zero");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:30] == 2'b00))
    else $error("LED write padding set");

  // no beat in the first cycle out of reset
  a_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("LED write out of reset");

endmodule

bind led_matrix_delta_refresh_unit lmdr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== dv/lmdr_frame_checker.sv =====
// frame predictor and led write scoreboard for the led matrix delta refresh unit
`timescale 1ns / 1ps
module lmdr_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // from_row, from_col, to_row, to_col, paint_color, back_color, digit
  input  logic [lmdr_pkg::IN_W-1:0]      s_tdata,
  // kind
  input  logic [1:0]                     s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // led_row, led_col, led_red, led_green, led_blue, two zero bits
  input  logic [lmdr_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [lmdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmdr_pkg::COLOR_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import lmdr_pkg::*;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } led_write_t;

  // predicted block state
  logic [COLOR_W-1:0] vacate_rgb;
  logic [COLOR_W-1:0] fill_rgb;
  logic [COLOR_W-1:0] target_rgb [CELLS];
  logic [COLOR_W-1:0] shown_rgb [CELLS];
  logic               shown_ok;
  led_write_t         led_writes_due [$];

  // glyph rows of each digit, top row in the upper bits
  function automatic logic [6:0] glyph_row_bits(input logic [3:0] d, input int r);
    logic [48:0] rows;
    case (d)
      4'd0: rows = {7'h1C, 7'h22, 7'h22, 7'h22, 7'h22, 7'h22, 7'h1C};
      4'd1: rows = {7'h10, 7'h18, 7'h14, 7'h12, 7'h10, 7'h10, 7'h10};
      4'd2: rows = {7'h1C, 7'h22, 7'h20, 7'h1C, 7'h02, 7'h02, 7'h04};
      4'd3: rows = {7'h1C, 7'h22, 7'h20, 7'h1C, 7'h20, 7'h22, 7'h1C};
      4'd4: rows = {7'h10, 7'h18, 7'h14, 7'h3E, 7'h10, 7'h10, 7'h10};
      4'd5: rows = {7'h3E, 7'h02, 7'h02, 7'h1E, 7'h20, 7'h20, 7'h1E};
      4'd6: rows = {7'h1C, 7'h22, 7'h02, 7'h1E, 7'h22, 7'h22, 7'h1C};
      4'd7: rows = {7'h3E, 7'h20, 7'h20, 7'h38, 7'h20, 7'h20, 7'h20};
      4'd8: rows = {7'h1C, 7'h22, 7'h22, 7'h1C, 7'h22, 7'h22, 7'h1C};
      4'd9: rows = {7'h1C, 7'h22, 7'h22, 7'h3C, 7'h20, 7'h22, 7'h1C};
      default: rows = '0;
    endcase
    return rows[(6 - r) * 7 +: 7];
  endfunction

  // out of range cells are dropped
  task automatic paint_cell(input logic [2:0] r, input logic [2:0] c,
                            input logic [COLOR_W-1:0] rgb);
    if (r < ROWS && c < COLS) begin
      target_rgb[r * COLS + c] = rgb;
    end
  endtask

  // queue one led write per changed cell, tlast on the final one
  task automatic refresh_leds();
    int         n;
    int         k;
    int         rr;
    int         cc;
    led_write_t w;
    n = 0;
    k = 0;
    for (int i = 0; i < CELLS; i++) begin
      if (!shown_ok || shown_rgb[i] != target_rgb[i]) n++;
    end
    for (int i = 0; i < CELLS; i++) begin
      if (!shown_ok || shown_rgb[i] != target_rgb[i]) begin
        shown_rgb[i] = target_rgb[i];
        rr = i / COLS + 1;
        cc = i % COLS + 1;
        w.row = rr[2:0];
        w.col = cc[2:0];
        w.red = target_rgb[i][23:16];
        w.green = target_rgb[i][15:8];
        w.blue = target_rgb[i][7:0];
        w.last = (k == n - 1);
        led_writes_due.push_back(w);
        k++;
      end
    end
    shown_ok = 1'b1;
  endtask

  task automatic apply_command(input kind_t k, input logic [IN_W-1:0] d);
    logic [6:0] bits;
    case (k)
      KIND_MOVE: begin
        paint_cell(d[2:0], d[5:3], vacate_rgb);
        paint_cell(d[8:6], d[11:9], d[35:12]);
        refresh_leds();
      end
      KIND_FILL: begin
        for (int i = 0; i < CELLS; i++) target_rgb[i] = fill_rgb;
        refresh_leds();
      end
      KIND_DIGIT: begin
        // digits above nine leave the frame alone
        if (d[63:60] <= 4'd9) begin
          for (int r = 0; r < GLYPH; r++) begin
            bits = glyph_row_bits(d[63:60], r);
            for (int c = 0; c < GLYPH; c++) begin
              paint_cell(r[2:0], c[2:0], bits[c] ? d[35:12] : d[59:36]);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t: led %s mismatch, expected %0h, actual %0h",
               $time, name, want_v, got_v);
    end
  endtask

  // watch config writes and both channels on every rising edge
  always @(posedge clk) begin : watch
    led_write_t got;
    led_write_t want;
    if (rst) begin
      vacate_rgb = '0;
      fill_rgb = '0;
      for (int i = 0; i < CELLS; i++) begin
        target_rgb[i] = '0;
        shown_rgb[i] = '0;
      end
      shown_ok = 1'b0;
      led_writes_due.delete();
      mismatches = 0;
    end else begin
      // output beat against the oldest predicted write
      if (m_tvalid && m_tready) begin
        got.row = m_tdata[2:0];
        got.col = m_tdata[5:3];
        got.red = m_tdata[13:6];
        got.green = m_tdata[21:14];
        got.blue = m_tdata[29:22];
        got.last = m_tlast;
        if (led_writes_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected led write, expected none, actual %0h last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = led_writes_due.pop_front();
          check_field("row", want.row, got.row);
          check_field("col", want.col, got.col);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("last", want.last, got.last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_VACATE) vacate_rgb = cfg_data;
        else if (cfg_index == CFG_FILL) fill_rgb = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        apply_command(kind_t'(s_tuser), s_tdata);
      end
    end
    outstanding = led_writes_due.size();
  end

endmodule

// ===== dv/led_matrix_delta_refresh_unit_tb.sv =====
// stimulus and verdict for the led matrix delta refresh unit
`timescale 1ns / 1ps
module led_matrix_delta_refresh_unit_tb;
  import lmdr_pkg::*;

  localparam int SETTLE_CYCLES = 250;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 42;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data = '0;
  int                   mismatches;
  int                   outstanding;
  int                   cycles = 0;
  bit                   quiet = 1'b0;
  logic [2:0]           token_row = 3'd0;
  logic [2:0]           token_col = 3'd0;

  always #1 clk = ~clk;

  led_matrix_delta_refresh_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lmdr_frame_checker frame_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // run time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls about a quarter of the time unless quiet
  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(0, 99) >= 24);
  end

  function automatic logic [IN_W-1:0] pack_cmd(input logic [2:0] fr, input logic [2:0] fc,
                                               input logic [2:0] tr, input logic [2:0] tc,
                                               input logic [23:0] paint,
                                               input logic [23:0] back,
                                               input logic [3:0] digit);
    return {digit, back, paint, tc, tr, fc, fr};
  endfunction

  // extremes often, random otherwise
  function automatic logic [23:0] pick_color();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    return 24'($urandom());
  endfunction

  // mostly inside the matrix, sometimes the out of range code
  function automatic logic [2:0] pick_pos();
    if ($urandom_range(0, 9) == 0) return 3'd7;
    return 3'($urandom_range(0, 6));
  endfunction

  // one command beat with random gaps before it
  task automatic send_cmd(input kind_t k, input logic [IN_W-1:0] d);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  // drain every predicted write, then let queued silent commands finish
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random command mix; counted is low for commands the block drops
  task automatic send_random(output bit counted);
    int              r;
    logic [IN_W-1:0] d;
    logic [2:0]      fr;
    logic [2:0]      fc;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    // half the time a command starts where the last token move ended
    if ($urandom_range(0, 1) == 0) begin
      fr = token_row;
      fc = token_col;
    end else begin
      fr = pick_pos();
      fc = pick_pos();
    end
    d = pack_cmd(fr, fc, pick_pos(), pick_pos(), pick_color(), pick_color(),
                 4'($urandom_range(0, 9)));
    if (r < 45) begin
      d[63:60] = 4'($urandom_range(0, 15));
      token_row = d[8:6];
      token_col = d[11:9];
      send_cmd(KIND_MOVE, d);
    end else if (r < 55) begin
      send_cmd(KIND_FILL, d);
    end else if (r < 88) begin
      send_cmd(KIND_DIGIT, d);
    end else if (r < 94) begin
      d[63:60] = 4'($urandom_range(10, 15));
      counted = 1'b0;
      send_cmd(KIND_DIGIT, d);
    end else begin
      counted = 1'b0;
      send_cmd(KIND_NOP, 64'({$urandom(), $urandom()}));
    end
  endtask

  initial begin
    int n;
    bit counted;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: first refresh writes every led
    send_cmd(KIND_MOVE, pack_cmd(3'd0, 3'd0, 3'd6, 3'd6, 24'hFFFFFF, 24'h0, 4'd0));
    // same start and end cell, end colour wins
    send_cmd(KIND_MOVE, pack_cmd(3'd3, 3'd3, 3'd3, 3'd3, 24'h123456, 24'hFFFFFF, 4'd15));
    // start cell out of range
    send_cmd(KIND_MOVE, pack_cmd(3'd7, 3'd7, 3'd2, 3'd4, 24'hA5C3E1, 24'h0, 4'd0));
    // end cell out of range, vacated cell already black: nothing changes
    send_cmd(KIND_MOVE, pack_cmd(3'd1, 3'd1, 3'd7, 3'd2, 24'hFFFFFF, 24'h0, 4'd0));
    send_cmd(KIND_MOVE, pack_cmd(3'd7, 3'd0, 3'd0, 3'd7, 24'h5A5A5A, 24'h0, 4'd0));
    // dropped commands
    send_cmd(KIND_NOP, {64{1'b1}});
    send_cmd(KIND_DIGIT, pack_cmd(3'd0, 3'd0, 3'd0, 3'd0, 24'hFFFFFF, 24'h0, 4'd10));
    send_cmd(KIND_DIGIT, pack_cmd(3'd0, 3'd0, 3'd0, 3'd0, 24'hFFFFFF, 24'h0, 4'd15));
    // every glyph, some of them shown by a following move
    for (int dg = 0; dg < 10; dg++) begin
      send_cmd(KIND_DIGIT, pack_cmd(3'd0, 3'd0, 3'd0, 3'd0, pick_color(), pick_color(),
                                    4'(dg)));
      if (dg % 2 == 1) begin
        send_cmd(KIND_MOVE, pack_cmd(3'd0, 3'd6, 3'd6, 3'd0, 24'hFFFFFF, 24'h0, 4'd0));
      end
    end
    send_cmd(KIND_FILL, pack_cmd(3'd0, 3'd0, 3'd0, 3'd0, 24'h0, 24'h0, 4'd0));

    // white vacate and fill colours
    settle();
    write_reg(CFG_VACATE, 24'hFFFFFF);
    write_reg(CFG_FILL, 24'hFFFFFF);
    send_cmd(KIND_FILL, '0);
    send_cmd(KIND_MOVE, pack_cmd(3'd6, 3'd6, 3'd0, 3'd0, 24'h000000, 24'h0, 4'd0));

    // random phases, each under a new register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_VACATE, (p == 0) ? 24'h000000 : (p == 1) ? 24'hFFFFFF : pick_color());
      write_reg(CFG_FILL, (p == 0) ? 24'hFFFFFF : (p == 1) ? 24'h000000 : pick_color());
      quiet = (p == 3);
      n = 0;
      while (n < PHASE_ITEMS) begin
        send_random(counted);
        if (counted) n++;
      end
    end
    quiet = 1'b0;

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lmdr_pkg.sv
rtl/lmdr_front.sv
rtl/lmdr_cmd_fifo.sv
rtl/lmdr_back.sv
rtl/led_matrix_delta_refresh_unit.sv
rtl/lmdr_checker.sv
dv/lmdr_frame_checker.sv
dv/led_matrix_delta_refresh_unit_tb.sv
